[rtl/multi_turn_angle_quantizer_core_assert.svh]
// ----------------------------------------------------------------------------
// multi_turn_angle_quantizer_core_assert
// Assertion macros for the turn counting quantizer.
// ----------------------------------------------------------------------------
// clocked on clk_i, disabled while rst_ni is low
`ifndef MULTI_TURN_ANGLE_QUANTIZER_CORE_ASSERT_SVH
`define MULTI_TURN_ANGLE_QUANTIZER_CORE_ASSERT_SVH

// same-cycle implication
`define MTAQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTAQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mtaq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtaq_pkg
// Shared widths, constants, types and helpers of the turn counting quantizer.
// ----------------------------------------------------------------------------
package mtaq_pkg;

  localparam int ANGLE_W     = 15;
  localparam int THR_W       = 14;
  localparam int LIM_W       = 3;
  localparam int STEP_W      = 4;
  localparam int TURNS_W     = 16;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 1;
  localparam int DISP_W      = 18;
  localparam int MAG_W       = 17;
  localparam int TCLAMP_W    = 3;

  localparam int TURN_COUNT_BITS_DEF = 16;

  localparam int FULL_TURN = 23040;
  localparam int STEP_SIZE = 640;
  localparam int TURN_CLAMP = 3;

  localparam logic [THR_W-1:0] WRAP_THR_RST  = THR_W'(10880);
  localparam logic [LIM_W-1:0] OUT_LIMIT_RST = LIM_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WRAP_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUT_LIMIT = CFG_IDX_W'(1);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [STEP_W-1:0]  step_t;
  typedef logic signed [TURNS_W-1:0] turns_t;

  typedef struct packed {
    logic [THR_W-1:0] wrap_thr;
    logic [LIM_W-1:0] out_limit;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic first;
  } axis_ctrl_t;

  // floor(m / 640), saturated at 7
  function automatic logic [LIM_W-1:0] step_mag(input logic [MAG_W-1:0] m);
    logic [LIM_W-1:0] q;
    q = '0;
    for (int k = 1; k < (1 << LIM_W); k++) begin
      if (m >= MAG_W'(k * STEP_SIZE)) begin
        q = LIM_W'(k);
      end
    end
    return q;
  endfunction

  function automatic logic step_within(input step_t s, input logic [LIM_W-1:0] lim);
    logic signed [STEP_W:0] sx;
    logic signed [STEP_W:0] lx;
    sx = (STEP_W+1)'(s);
    lx = $signed({2'b00, lim});
    return (sx <= lx) && (sx >= -lx);
  endfunction

endpackage

[rtl/mtaq_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtaq_in_if
// Request channel carrying one three-axis orientation sample.
// ----------------------------------------------------------------------------
interface mtaq_in_if;
  logic            valid;
  logic            ready;
  mtaq_pkg::angle_t angle_yaw;
  mtaq_pkg::angle_t angle_pitch;
  mtaq_pkg::angle_t angle_roll;

  modport source (output valid, output angle_yaw, output angle_pitch,
                  output angle_roll, input ready);
  modport sink (input valid, input angle_yaw, input angle_pitch,
                input angle_roll, output ready);
endinterface

[rtl/mtaq_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtaq_out_if
// Result channel carrying step and turn count of each axis.
// ----------------------------------------------------------------------------
interface mtaq_out_if;
  logic             valid;
  logic             ready;
  mtaq_pkg::step_t  step_yaw;
  mtaq_pkg::step_t  step_pitch;
  mtaq_pkg::step_t  step_roll;
  mtaq_pkg::turns_t turns_yaw;
  mtaq_pkg::turns_t turns_pitch;
  mtaq_pkg::turns_t turns_roll;

  modport source (output valid, output step_yaw, output step_pitch, output step_roll,
                  output turns_yaw, output turns_pitch, output turns_roll, input ready);
  modport sink (input valid, input step_yaw, input step_pitch, input step_roll,
                input turns_yaw, input turns_pitch, input turns_roll, output ready);
endinterface

[rtl/mtaq_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtaq_cfg
// Configuration registers: wrap threshold and output clamp limit.
// ----------------------------------------------------------------------------
module mtaq_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mtaq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mtaq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output mtaq_pkg::cfg_t                     cfg_o
);

  logic [mtaq_pkg::THR_W-1:0] wrap_thr_q;
  logic [mtaq_pkg::LIM_W-1:0] out_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_thr_q  <= mtaq_pkg::WRAP_THR_RST;
      out_limit_q <= mtaq_pkg::OUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mtaq_pkg::CFG_IDX_WRAP_THR: begin
          wrap_thr_q <= cfg_data_i[mtaq_pkg::THR_W-1:0];
        end
        mtaq_pkg::CFG_IDX_OUT_LIMIT: begin
          out_limit_q <= cfg_data_i[mtaq_pkg::LIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.wrap_thr  = wrap_thr_q;
  assign cfg_o.out_limit = out_limit_q;

endmodule

[rtl/mtaq_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtaq_axis
// One axis: wrap detection, saturating turn counter, start latch and
// quantized clamped displacement.
// ----------------------------------------------------------------------------
module mtaq_axis #(
  parameter int TURN_COUNT_BITS = mtaq_pkg::TURN_COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtaq_pkg::axis_ctrl_t ctrl_i,
  input  mtaq_pkg::cfg_t       cfg_i,
  input  mtaq_pkg::angle_t     angle_i,
  output mtaq_pkg::step_t      step_o,
  output mtaq_pkg::turns_t     turns_o
);

  localparam logic signed [TURN_COUNT_BITS-1:0] TMAX = {1'b0, {(TURN_COUNT_BITS-1){1'b1}}};
  localparam logic signed [TURN_COUNT_BITS-1:0] TMIN = -TMAX;
  localparam logic signed [mtaq_pkg::DISP_W-1:0] FULL_TURN_D =
    mtaq_pkg::DISP_W'(mtaq_pkg::FULL_TURN);

  mtaq_pkg::angle_t                   prev_q;
  mtaq_pkg::angle_t                   start_q;
  mtaq_pkg::angle_t                   start_d;
  logic signed [TURN_COUNT_BITS-1:0]  turns_q;
  logic signed [TURN_COUNT_BITS-1:0]  turns_d;

  logic signed [mtaq_pkg::ANGLE_W:0]  prev_x;
  logic signed [mtaq_pkg::ANGLE_W:0]  ang_x;
  logic signed [mtaq_pkg::ANGLE_W:0]  thr_x;
  logic                               wrap_up;
  logic                               wrap_dn;
  logic signed [31:0]                 turns_w;
  logic signed [mtaq_pkg::TCLAMP_W-1:0] turns_c;
  logic signed [mtaq_pkg::DISP_W-1:0] disp;
  logic [mtaq_pkg::MAG_W-1:0]         mag;
  logic [mtaq_pkg::LIM_W-1:0]         q;
  logic [mtaq_pkg::LIM_W-1:0]         s;

  always_comb begin
    prev_x  = (mtaq_pkg::ANGLE_W+1)'(prev_q);
    ang_x   = (mtaq_pkg::ANGLE_W+1)'(angle_i);
    thr_x   = $signed({2'b00, cfg_i.wrap_thr});
    wrap_up = (prev_x > thr_x) && (ang_x < -thr_x);
    wrap_dn = (ang_x > thr_x) && (prev_x < -thr_x);

    turns_d = turns_q;
    if (wrap_up) begin
      if (turns_q != TMAX) begin
        turns_d = turns_q + TURN_COUNT_BITS'(1);
      end
    end else if (wrap_dn) begin
      if (turns_q != TMIN) begin
        turns_d = turns_q - TURN_COUNT_BITS'(1);
      end
    end

    start_d = ctrl_i.first ? angle_i : start_q;

    // beyond three turns the step saturates anyway
    turns_w = 32'(turns_d);
    if (turns_w > 32'(mtaq_pkg::TURN_CLAMP)) begin
      turns_c = mtaq_pkg::TCLAMP_W'(mtaq_pkg::TURN_CLAMP);
    end else if (turns_w < -32'(mtaq_pkg::TURN_CLAMP)) begin
      turns_c = -mtaq_pkg::TCLAMP_W'(mtaq_pkg::TURN_CLAMP);
    end else begin
      turns_c = turns_w[mtaq_pkg::TCLAMP_W-1:0];
    end

    disp = mtaq_pkg::DISP_W'(start_d) - mtaq_pkg::DISP_W'(angle_i)
         + FULL_TURN_D * mtaq_pkg::DISP_W'(turns_c);
    mag  = disp[mtaq_pkg::DISP_W-1] ? mtaq_pkg::MAG_W'(-disp) : mtaq_pkg::MAG_W'(disp);
    q    = mtaq_pkg::step_mag(mag);
    s    = (q > cfg_i.out_limit) ? cfg_i.out_limit : q;

    step_o  = disp[mtaq_pkg::DISP_W-1] ? -$signed({1'b0, s}) : $signed({1'b0, s});
    turns_o = turns_w[mtaq_pkg::TURNS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      start_q <= '0;
      turns_q <= '0;
    end else if (ctrl_i.advance) begin
      prev_q  <= angle_i;
      start_q <= start_d;
      turns_q <= turns_d;
    end
  end

endmodule

[rtl/multi_turn_angle_quantizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_turn_angle_quantizer_core
// Per-axis turn counting and 10 degree quantization of orientation samples.
//
//   channel  dir  handshake    payload
//   in_i     in   valid/ready  angle_yaw, angle_pitch, angle_roll
//   out_o    out  valid/ready  step_*, turns_* per axis
//
// a request passes the input register, then the result register
// one request per cycle sustained while out_o.ready is high; the axis logic sits between the two registers
// state is updated as a request moves into the result register
// a stalled result holds while one more request waits in the input register
// reset clears valid flags, turn counts and stored angles, and sets the first-sample flag
// ----------------------------------------------------------------------------
`include "multi_turn_angle_quantizer_core_assert.svh"

module multi_turn_angle_quantizer_core #(
  parameter int TURN_COUNT_BITS = mtaq_pkg::TURN_COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mtaq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mtaq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mtaq_in_if.sink                         in_i,
  mtaq_out_if.source                      out_o
);

  localparam int NUM_AXES = 3;

  mtaq_pkg::cfg_t       cfg;
  mtaq_pkg::axis_ctrl_t ctrl;

  logic             s1_valid_q;
  mtaq_pkg::angle_t s1_angle_q [NUM_AXES];
  logic             out_valid_q;
  mtaq_pkg::step_t  step_q     [NUM_AXES];
  mtaq_pkg::turns_t turns_q    [NUM_AXES];
  mtaq_pkg::step_t  step_w     [NUM_AXES];
  mtaq_pkg::turns_t turns_w    [NUM_AXES];
  logic             first_q;
  logic             advance;
  logic             in_fire;
  logic             steps_ok;

  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  assign ctrl.advance = advance;
  assign ctrl.first   = first_q;

  mtaq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    mtaq_axis #(
      .TURN_COUNT_BITS (TURN_COUNT_BITS)
    ) u_axis (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .cfg_i   (cfg),
      .angle_i (s1_angle_q[a]),
      .step_o  (step_w[a]),
      .turns_o (turns_w[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b1;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        first_q     <= 1'b0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_angle_q[0] <= in_i.angle_yaw;
      s1_angle_q[1] <= in_i.angle_pitch;
      s1_angle_q[2] <= in_i.angle_roll;
    end
    if (advance) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        step_q[a]  <= step_w[a];
        turns_q[a] <= turns_w[a];
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.step_yaw    = step_q[0];
  assign out_o.step_pitch  = step_q[1];
  assign out_o.step_roll   = step_q[2];
  assign out_o.turns_yaw   = turns_q[0];
  assign out_o.turns_pitch = turns_q[1];
  assign out_o.turns_roll  = turns_q[2];

  assign steps_ok = mtaq_pkg::step_within(step_q[0], cfg.out_limit)
                 && mtaq_pkg::step_within(step_q[1], cfg.out_limit)
                 && mtaq_pkg::step_within(step_q[2], cfg.out_limit);

  `MTAQ_ASSERT_IMP(a_ready_only_when_full, !in_i.ready, s1_valid_q && out_valid_q, "input stalled without a full pipeline")
  `MTAQ_ASSERT_NXT(a_advance_gives_result, advance, out_valid_q, "advanced request produced no result")
  `MTAQ_ASSERT_NXT(a_first_cleared, advance, !first_q, "first-sample flag still set after a request")
  `MTAQ_ASSERT_IMP(a_steps_clamped, out_valid_q && !cfg_we_i, steps_ok, "step output outside the clamp limit")

endmodule
